// ===== rtl/core/alsl_pkg.sv =====
// Shared types, constants and microcode definitions for the antialiased line stepper.
package alsl_pkg;

	localparam int COORD_BITS = 11;
	localparam int CFG_BITS   = 12;
	localparam int ADDR_BITS  = 22;
	localparam int COLOR_BITS = 24;
	localparam int PROD_BITS  = COORD_BITS + 1 + CFG_BITS;
	localparam int UPC_BITS   = 3;

	localparam logic [COLOR_BITS-1:0] BASE_COLOR       = 24'hCC0000;
	localparam logic [CFG_BITS-1:0]   LINE_WIDTH_RESET = 12'd1024;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// microcode addresses
	localparam logic [UPC_BITS-1:0] UA_DISPATCH = 3'd0;
	localparam logic [UPC_BITS-1:0] UA_SETUP    = 3'd1;
	localparam logic [UPC_BITS-1:0] UA_DIVINIT  = 3'd2;
	localparam logic [UPC_BITS-1:0] UA_DIVSTEP  = 3'd3;
	localparam logic [UPC_BITS-1:0] UA_FINISH   = 3'd4;

	typedef enum logic [1:0] {
		KIND_VERT    = 2'd0,
		KIND_HORZ    = 2'd1,
		KIND_SHALLOW = 2'd2,
		KIND_STEEP   = 2'd3
	} line_kind_t;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_MID   = 2'd1,
		PH_LAST  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		COND_NEXT     = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_NO_START = 3'd2,
		COND_NOT_DIAG = 3'd3,
		COND_DIV_MORE = 3'd4
	} jmp_cond_t;

	typedef struct packed {
		jmp_cond_t           cond;
		logic [UPC_BITS-1:0] target;
		logic                take_in;
		logic                setup;
		logic                div_init;
		logic                div_step;
		logic                finish;
	} ucode_t;

	typedef struct packed {
		logic start_fire;
		logic diag;
		logic div_more;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		logic                  opcode;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_finish;
		logic [COORD_BITS-1:0] y_finish;
	} in_t;

	typedef struct packed {
		logic                  first_valid;
		logic [ADDR_BITS-1:0]  first_addr;
		logic [COLOR_BITS-1:0] first_color;
		logic                  second_valid;
		logic [ADDR_BITS-1:0]  second_addr;
		logic [COLOR_BITS-1:0] second_color;
		logic                  line_done;
	} out_t;

endpackage

// ===== rtl/core/alsl_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module alsl_sequencer
	import alsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t st,
	output ucode_t      ctl
);

	logic [UPC_BITS-1:0] upc_q;
	logic [UPC_BITS-1:0] upc_next;
	logic                take_jump;

	function automatic ucode_t rom_word(input logic [UPC_BITS-1:0] addr);
		ucode_t w;
		w = '0;
		unique case (addr)
			UA_DISPATCH: begin
				w.take_in = 1'b1;
				w.cond    = COND_NO_START;
				w.target  = UA_DISPATCH;
			end
			UA_SETUP: begin
				w.setup  = 1'b1;
				w.cond   = COND_NOT_DIAG;
				w.target = UA_FINISH;
			end
			UA_DIVINIT: begin
				w.div_init = 1'b1;
				w.cond     = COND_NEXT;
				w.target   = UA_DISPATCH;
			end
			UA_DIVSTEP: begin
				w.div_step = 1'b1;
				w.cond     = COND_DIV_MORE;
				w.target   = UA_DIVSTEP;
			end
			UA_FINISH: begin
				w.finish = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = UA_DISPATCH;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = UA_DISPATCH;
			end
		endcase
		return w;
	endfunction

	assign ctl = rom_word(upc_q);

	always_comb begin
		unique case (ctl.cond)
			COND_NEXT:     take_jump = 1'b0;
			COND_ALWAYS:   take_jump = 1'b1;
			COND_NO_START: take_jump = !st.start_fire;
			COND_NOT_DIAG: take_jump = !st.diag;
			COND_DIV_MORE: take_jump = st.div_more;
			default:       take_jump = 1'b1;
		endcase
		if (ctl.finish && !st.out_free) begin
			upc_next = upc_q;
		end else if (take_jump) begin
			upc_next = ctl.target;
		end else begin
			upc_next = upc_q + UPC_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_DISPATCH;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ===== rtl/core/alsl_datapath.sv =====
// Line state, setup logic, shared restoring divider and per-step pixel datapath.
module alsl_datapath
	import alsl_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int COVER_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ucode_t              ctl,
	input  logic                start_fire,
	input  logic                step_fire,
	input  in_t                 in_data,
	input  logic [CFG_BITS-1:0] line_width,
	output logic                diag,
	output logic                div_more,
	output out_t                result
);

	localparam int ACC_W   = COORD_BITS + FRAC_BITS + 1;
	localparam int SLOPE_W = FRAC_BITS + 2;
	localparam int QUO_W   = FRAC_BITS + 1;
	localparam int CNT_W   = $clog2(FRAC_BITS + 1);
	localparam int COV_W   = COVER_BITS + 1;
	localparam int CPROD_W = COLOR_BITS + COV_W;
	localparam logic [COV_W-1:0] COV_FULL = {1'b1, {COVER_BITS{1'b0}}};
	localparam logic [COV_W-1:0] COV_HALF = {2'b01, {(COVER_BITS-1){1'b0}}};

	// control state
	logic                 busy_q;
	line_kind_t           kind_q;
	phase_t               phase_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	// payload state
	logic [COORD_BITS-1:0] xa_q, ya_q, xb_q, yb_q;
	logic [COORD_BITS-1:0] major_pos_q, major_stop_q, minor_stop_q;
	logic [ACC_W-1:0]      accum_q;
	logic [SLOPE_W-1:0]    slope_q;
	logic [COORD_BITS-1:0] den_q, rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic                  neg_q;

	// setup
	logic [COORD_BITS-1:0] dx, dy, mj0, mj1, mn0, mn1, len, mdel;
	logic                  coincident, swap, y_major_new;
	line_kind_t            kind_new;

	always_comb begin
		dx = (xb_q > xa_q) ? xb_q - xa_q : xa_q - xb_q;
		dy = (yb_q > ya_q) ? yb_q - ya_q : ya_q - yb_q;
		coincident = (xa_q == xb_q) && (ya_q == yb_q);
		if (xa_q == xb_q) begin
			kind_new = KIND_VERT;
		end else if (ya_q == yb_q) begin
			kind_new = KIND_HORZ;
		end else if (dy < dx) begin
			kind_new = KIND_SHALLOW;
		end else begin
			kind_new = KIND_STEEP;
		end
		y_major_new = (kind_new == KIND_VERT) || (kind_new == KIND_STEEP);
		if (y_major_new) begin
			swap = yb_q < ya_q;
			mj0  = swap ? yb_q : ya_q;
			mj1  = swap ? ya_q : yb_q;
			mn0  = swap ? xb_q : xa_q;
			mn1  = swap ? xa_q : xb_q;
		end else begin
			swap = xb_q < xa_q;
			mj0  = swap ? xb_q : xa_q;
			mj1  = swap ? xa_q : xb_q;
			mn0  = swap ? yb_q : ya_q;
			mn1  = swap ? ya_q : yb_q;
		end
		len  = mj1 - mj0;
		mdel = (mn1 > mn0) ? mn1 - mn0 : mn0 - mn1;
		diag = !coincident && ((kind_new == KIND_SHALLOW) || (kind_new == KIND_STEEP));
	end

	// divider: one quotient bit per step
	logic [COORD_BITS:0] rem_dbl, rem_sub;
	logic                rem_ge;

	always_comb begin
		rem_dbl = {rem_q, 1'b0};
		rem_sub = rem_dbl - {1'b0, den_q};
		rem_ge  = rem_dbl >= {1'b0, den_q};
	end

	assign div_more = cnt_q != CNT_W'(1);

	// per-step pixel datapath
	logic [COORD_BITS-1:0]             m_lo;
	logic [COORD_BITS:0]               m_wide;
	logic [FRAC_BITS+COVER_BITS-1:0]   frac_wide;
	logic [COVER_BITS-1:0]             c2;
	logic [COORD_BITS-1:0]             major_sel;
	logic [COORD_BITS:0]               minor_sel;
	logic [COV_W-1:0]                  cov1, cov2;
	logic                              two_pix, y_major, axis;
	logic [COORD_BITS:0]               px, py;
	logic [PROD_BITS-1:0]              addr_sum;
	logic [ADDR_BITS-1:0]              addr1, addr2;
	logic [COORD_BITS-1:0]             pos_next;
	logic                              at_end;
	out_t                              step_res, start_res;

	function automatic logic [COLOR_BITS-1:0] color_of(input logic [COV_W-1:0] cov);
		logic [CPROD_W-1:0] p;
		p = CPROD_W'(BASE_COLOR) * CPROD_W'(cov);
		return p[COVER_BITS +: COLOR_BITS];
	endfunction

	always_comb begin
		m_lo      = accum_q[FRAC_BITS +: COORD_BITS];
		m_wide    = accum_q[FRAC_BITS +: COORD_BITS + 1];
		frac_wide = {accum_q[FRAC_BITS-1:0], {COVER_BITS{1'b0}}};
		c2        = frac_wide[FRAC_BITS +: COVER_BITS];
		y_major   = (kind_q == KIND_VERT) || (kind_q == KIND_STEEP);
		axis      = (kind_q == KIND_VERT) || (kind_q == KIND_HORZ);

		major_sel = major_pos_q;
		minor_sel = {1'b0, m_lo};
		cov1      = COV_FULL;
		cov2      = '0;
		two_pix   = 1'b0;
		if (!axis) begin
			two_pix = 1'b1;
			case (phase_q)
				PH_FIRST: begin
					cov1 = COV_HALF;
				end
				PH_MID: begin
					minor_sel = m_wide;
					cov1      = COV_FULL - {1'b0, c2};
					cov2      = {1'b0, c2};
				end
				default: begin
					major_sel = major_stop_q;
					minor_sel = {1'b0, minor_stop_q};
					cov1      = COV_HALF;
				end
			endcase
		end

		px = y_major ? minor_sel : {1'b0, major_sel};
		py = y_major ? {1'b0, major_sel} : minor_sel;
		addr_sum = PROD_BITS'(py) * PROD_BITS'(line_width) + PROD_BITS'(px);
		addr1    = addr_sum[ADDR_BITS-1:0];
		// the neighbor sits one step further along the minor axis
		addr2    = addr1 + (y_major ? ADDR_BITS'(1) : ADDR_BITS'(line_width));

		pos_next = major_pos_q + COORD_BITS'(1);
		at_end   = pos_next == major_stop_q;

		step_res = '0;
		if (busy_q) begin
			step_res.first_valid = 1'b1;
			step_res.first_addr  = addr1;
			step_res.first_color = color_of(cov1);
			if (two_pix) begin
				step_res.second_valid = 1'b1;
				step_res.second_addr  = addr2;
				step_res.second_color = color_of(cov2);
			end
			if (axis) begin
				step_res.line_done = at_end;
			end else begin
				step_res.line_done = (phase_q == PH_LAST);
			end
		end

		start_res           = '0;
		start_res.line_done = done_q;
		result = ctl.finish ? start_res : step_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			kind_q  <= KIND_VERT;
			phase_q <= PH_FIRST;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (ctl.setup) begin
				busy_q  <= !coincident;
				kind_q  <= kind_new;
				phase_q <= PH_FIRST;
				done_q  <= coincident;
			end else if (ctl.div_init) begin
				cnt_q <= CNT_W'(FRAC_BITS);
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end else if (step_fire && busy_q) begin
				if (axis) begin
					if (at_end) begin
						busy_q <= 1'b0;
					end
				end else begin
					case (phase_q)
						PH_FIRST: phase_q <= at_end ? PH_LAST : PH_MID;
						PH_MID: begin
							if (at_end) begin
								phase_q <= PH_LAST;
							end
						end
						default: begin
							busy_q  <= 1'b0;
							phase_q <= PH_FIRST;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_fire) begin
			xa_q <= in_data.x_start;
			ya_q <= in_data.y_start;
			xb_q <= in_data.x_finish;
			yb_q <= in_data.y_finish;
		end
		if (ctl.setup) begin
			major_pos_q  <= mj0;
			major_stop_q <= mj1;
			minor_stop_q <= mn1;
			accum_q      <= {1'b0, mn0, {FRAC_BITS{1'b0}}};
			slope_q      <= '0;
			den_q        <= len;
			rem_q        <= mdel;
			quo_q        <= '0;
			neg_q        <= mn1 < mn0;
		end else if (ctl.div_init) begin
			// integer part is one only when the minor delta equals the length
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				quo_q <= QUO_W'(1);
			end else begin
				quo_q <= '0;
			end
		end else if (ctl.div_step) begin
			rem_q <= rem_ge ? rem_sub[COORD_BITS-1:0] : rem_dbl[COORD_BITS-1:0];
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
		end else if (ctl.finish) begin
			slope_q <= neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		end else if (step_fire && busy_q && !axis && (phase_q != PH_LAST)) begin
			major_pos_q <= pos_next;
			accum_q     <= accum_q + {{(ACC_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
		end else if (step_fire && busy_q && axis) begin
			major_pos_q <= pos_next;
		end
	end

endmodule

// ===== rtl/core/antialiased_line_stepper.sv =====
// Top level of the antialiased line stepper: handshakes, width register, output register.
//
// Draws one antialiased line at a time from integer endpoints. A start transaction
// (opcode 0) loads the endpoints; the block sorts them along the major axis and, for a
// diagonal line, runs a restoring divider that yields one gradient bit per cycle. No new
// transaction is taken until a start has passed its setup, divide and finish words; a
// horizontal, vertical or single-point start skips the divide words. Its result transaction
// carries no pixels and flags line_done only when both endpoints coincide. A step
// transaction (opcode 1) is taken in the dispatch word, and each one can
// follow the previous one back to back: it yields the next column or row as up to two
// framebuffer writes, address x + y*line_width modulo 2^22 and color 0xCC0000 scaled by
// the pixel coverage; the last step of a line raises line_done. A step with no line
// active returns an empty result. The divide loop is sequenced by a small microcode
// store, and results leave through a single output register, so a transaction is
// accepted only when that register is empty or is being read in the same cycle; while
// out_ready stays low the input stalls, and a start holds its final cycle until the
// register frees. Write line_width only while the block is idle.
module antialiased_line_stepper
	import alsl_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int COVER_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_t                 in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_t                out_data
);

	logic [CFG_BITS-1:0] line_width_q;
	logic                out_valid_q;
	out_t                out_data_q;
	logic                out_free;
	logic                in_fire;
	logic                start_fire;
	logic                step_fire;
	logic                load_out;
	logic                diag;
	logic                div_more;
	ucode_t              ctl;
	seq_status_t         st;
	out_t                result;

	// Output register can take a new result when empty or being drained this cycle.
	assign out_free   = !out_valid_q || out_ready;
	// Accept only in the dispatch word, and only when a step result has somewhere to go.
	assign in_ready   = ctl.take_in && out_free;
	assign in_fire    = in_valid && in_ready;
	assign start_fire = in_fire && (in_data.opcode == OP_START);
	assign step_fire  = in_fire && (in_data.opcode == OP_STEP);
	// Load a step result at once, a start result when the finish word runs.
	assign load_out   = out_free && (step_fire || ctl.finish);

	always_comb begin
		st            = '0;
		st.start_fire = start_fire;
		st.diag       = diag;
		st.div_more   = div_more;
		st.out_free   = out_free;
	end

	alsl_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	alsl_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.COVER_BITS (COVER_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.start_fire (start_fire),
		.step_fire  (step_fire),
		.in_data    (in_data),
		.line_width (line_width_q),
		.diag       (diag),
		.div_more   (div_more),
		.result     (result)
	);

	// Hold the row pitch; writes land immediately.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	// Advance the output valid flag; drop it once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
